[src/pfs_pkg.sv]
// Shared types, register indexes and fixed-point helpers of the path following
// steering core. Used by pfs_datapath, pfs_ctrl and the top-level core.
`default_nettype none

package pfs_pkg;

   localparam int unsigned AddrWidth = 5;

   localparam logic [2:0] REG_PATH_BEGIN_X = 3'd0;
   localparam logic [2:0] REG_PATH_BEGIN_Y = 3'd1;
   localparam logic [2:0] REG_PATH_END_X   = 3'd2;
   localparam logic [2:0] REG_PATH_END_Y   = 3'd3;
   localparam logic [2:0] REG_PATH_RADIUS  = 3'd4;
   localparam logic [2:0] REG_MAX_SPEED    = 3'd5;
   localparam logic [2:0] REG_MAX_FORCE    = 3'd6;
   localparam logic [2:0] REG_LOOKAHEAD    = 3'd7;

   localparam logic [30:0] MAX_SPEED_RESET = 31'd131072;
   localparam logic [30:0] MAX_FORCE_RESET = 31'd655;
   localparam logic [30:0] LOOKAHEAD_RESET = 31'd8192000;
   localparam logic signed [31:0] VEL_RESET = 32'sd150733;

   typedef struct packed {
      logic signed [31:0] begin_x;
      logic signed [31:0] begin_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic [30:0]        radius;
      logic [30:0]        speed;
      logic [30:0]        force_mag;
      logic [30:0]        look;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_TAKE,
      OP_ADV_POS,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQRT,
      OP_DIV_X,
      OP_DIV_X_WAIT,
      OP_DIV_Y,
      OP_DIV_Y_WAIT,
      OP_UNIT_ZERO,
      OP_FUT_MX,
      OP_FUT_AX,
      OP_FUT_AY,
      OP_FUT_D,
      OP_DOT_M1,
      OP_DOT_M2,
      OP_DOT_SUM,
      OP_CL_MX,
      OP_CL_MY,
      OP_AIM_X,
      OP_AIM_Y,
      OP_DIST,
      OP_SEEK_M1,
      OP_SEEK_M2,
      OP_SEEK_M3,
      OP_FRC_M1,
      OP_FRC_M2,
      OP_FRC_M3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic sqrt_busy;
      logic div_done;
      logic div_busy;
      logic len_zero;
      logic len_over;
   } stat_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return s[31:0];
   endfunction

   // divide by 2^16 toward zero, then clamp to 32 bits
   function automatic logic signed [31:0] qfix(input logic signed [65:0] p);
      logic signed [49:0] t;
      t = p[65:16];
      if (p[65] && (p[15:0] != 16'd0)) begin
         t = t + 50'sd1;
      end
      if (t > 50'sd2147483647) begin
         return 32'sh7fff_ffff;
      end
      if (t < -50'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return t[31:0];
   endfunction

   function automatic logic signed [31:0] times10(input logic signed [31:0] p);
      return (p <<< 3) + (p <<< 1);
   endfunction

endpackage

`default_nettype wire

[src/pfs_ifs.sv]
// Request and response channel interfaces of the path following steering core.
// Depends on nothing.
`default_nettype none

interface pfs_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] set_pos_x;
   logic signed [31:0] set_pos_y;
   logic signed [31:0] set_vel_x;
   logic signed [31:0] set_vel_y;

   modport source (output valid, mode, set_pos_x, set_pos_y, set_vel_x, set_vel_y,
                   input ready);
   modport sink (input valid, mode, set_pos_x, set_pos_y, set_vel_x, set_vel_y,
                 output ready);
endinterface

interface pfs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] aim_x;
   logic signed [31:0] aim_y;
   logic               steering_on;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, aim_x, aim_y, steering_on,
                   input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, aim_x, aim_y, steering_on,
                 output ready);
endinterface

`default_nettype wire

[src/pfs_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Standalone; no package use.
`default_nettype none

module pfs_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic [31:0]      root,
   output logic             done,
   output logic             busy
);

   logic [63:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff[33:0], rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[61:0], 2'b00};
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[30:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;
   assign busy = busy_ff;

endmodule

`default_nettype wire

[src/pfs_div.sv]
// Iterative divider for unit vector components: (num * 2^16) / den toward zero.
// Assumes |num| <= den, so the quotient fits 17 bits. No package use.
`default_nettype none

module pfs_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic        [31:0] den,
   output logic signed [31:0]      quo,
   output logic                    done,
   output logic                    busy
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [16:0] sh_ff, sh_in;
   logic [16:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mag;
   logic [32:0] t;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      mag     = num[31] ? (~num + 32'd1) : num;
      t       = {rem_ff, sh_ff[16]};
      diff    = t - {1'b0, den_ff};
      ge      = t >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, mag[31:1]};
         sh_in   = {mag[0], 16'd0};
         den_in  = den;
         q_in    = '0;
         cnt_in  = '0;
         neg_in  = num[31];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : t[31:0];
         sh_in  = {sh_ff[15:0], 1'b0};
         q_in   = {q_ff[15:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = neg_ff ? -$signed({15'd0, q_ff}) : $signed({15'd0, q_ff});
   assign done = done_ff;
   assign busy = busy_ff;

endmodule

`default_nettype wire

[src/pfs_datapath.sv]
// Datapath: agent state, shared multiplier, square root and divider units.
// Depends on pfs_pkg, pfs_sqrt and pfs_div; driven by commands from pfs_ctrl.
`default_nettype none

module pfs_datapath import pfs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire cfg_type            cfg,
   input  wire logic               req_mode,
   input  wire logic signed [31:0] req_set_pos_x,
   input  wire logic signed [31:0] req_set_pos_y,
   input  wire logic signed [31:0] req_set_vel_x,
   input  wire logic signed [31:0] req_set_vel_y,
   output stat_type                stat,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_vel_x,
   output logic signed [31:0]      rsp_vel_y,
   output logic signed [31:0]      rsp_aim_x,
   output logic signed [31:0]      rsp_aim_y,
   output logic                    rsp_steering_on
);

   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0] frc_x_ff, frc_x_in, frc_y_ff, frc_y_in;
   logic signed [31:0] ua_x_ff, ua_x_in, ua_y_ff, ua_y_in;
   logic signed [31:0] un_x_ff, un_x_in, un_y_ff, un_y_in;
   logic signed [31:0] p_x_ff, p_x_in, p_y_ff, p_y_in;
   logic signed [31:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [31:0] dot_ff, dot_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] aim_x_ff, aim_x_in, aim_y_ff, aim_y_in;
   logic               steer_ff, steer_in;
   logic signed [65:0] mp_ff, mp_in, acc_ff, acc_in;
   logic signed [31:0] o_pos_x_ff, o_pos_x_in, o_pos_y_ff, o_pos_y_in;
   logic signed [31:0] o_vel_x_ff, o_vel_x_in, o_vel_y_ff, o_vel_y_in;
   logic signed [31:0] o_aim_x_ff, o_aim_x_in, o_aim_y_ff, o_aim_y_in;
   logic               o_steer_ff, o_steer_in;

   logic signed [32:0] mul_a, mul_b;
   logic               mul_en;
   logic               sqrt_start, div_start;
   logic signed [31:0] div_num;
   logic [63:0]        radicand;
   logic [31:0]        len;
   logic signed [31:0] div_q;
   logic               sqrt_done, sqrt_busy, div_done, div_busy;

   assign radicand = acc_ff[63:0] + mp_ff[63:0];

   pfs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .root     (len),
      .done     (sqrt_done),
      .busy     (sqrt_busy)
   );

   pfs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len),
      .quo   (div_q),
      .done  (div_done),
      .busy  (div_busy)
   );

   always_comb begin
      stat.sqrt_done = sqrt_done;
      stat.sqrt_busy = sqrt_busy;
      stat.div_done  = div_done;
      stat.div_busy  = div_busy;
      stat.len_zero  = len == 32'd0;
      stat.len_over  = len > {1'b0, cfg.radius};
   end

   always_comb begin
      pos_x_in = pos_x_ff;  pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff;  vel_y_in = vel_y_ff;
      frc_x_in = frc_x_ff;  frc_y_in = frc_y_ff;
      ua_x_in  = ua_x_ff;   ua_y_in  = ua_y_ff;
      un_x_in  = un_x_ff;   un_y_in  = un_y_ff;
      p_x_in   = p_x_ff;    p_y_in   = p_y_ff;
      fx_in    = fx_ff;     fy_in    = fy_ff;
      dx_in    = dx_ff;     dy_in    = dy_ff;
      dot_in   = dot_ff;
      cx_in    = cx_ff;     cy_in    = cy_ff;
      aim_x_in = aim_x_ff;  aim_y_in = aim_y_ff;
      steer_in = steer_ff;
      acc_in   = acc_ff;
      mul_a      = '0;
      mul_b      = '0;
      mul_en     = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      div_num    = ua_x_ff;
      case (cmd.op)
         OP_TAKE: begin
            frc_x_in = '0;
            frc_y_in = '0;
            steer_in = 1'b0;
            aim_x_in = '0;
            aim_y_in = '0;
            if (req_mode) begin
               pos_x_in = req_set_pos_x;
               pos_y_in = req_set_pos_y;
               vel_x_in = req_set_vel_x;
               vel_y_in = req_set_vel_y;
            end else begin
               vel_x_in = sat_add(vel_x_ff, frc_x_ff);
               vel_y_in = sat_add(vel_y_ff, frc_y_ff);
            end
         end
         OP_ADV_POS: begin
            pos_x_in = sat_add(pos_x_ff, vel_x_ff);
            pos_y_in = sat_add(pos_y_ff, vel_y_ff);
            ua_x_in  = vel_x_ff;
            ua_y_in  = vel_y_ff;
         end
         OP_SQ_X: begin
            mul_a = {ua_x_ff[31], ua_x_ff};  mul_b = {ua_x_ff[31], ua_x_ff};
            mul_en = 1'b1;
         end
         OP_SQ_Y: begin
            acc_in = mp_ff;
            mul_a = {ua_y_ff[31], ua_y_ff};  mul_b = {ua_y_ff[31], ua_y_ff};
            mul_en = 1'b1;
         end
         OP_SQRT: sqrt_start = 1'b1;
         OP_DIV_X: begin
            div_start = 1'b1;
            div_num   = ua_x_ff;
         end
         OP_DIV_X_WAIT: begin
            if (div_done) begin
               un_x_in = div_q;
            end
         end
         OP_DIV_Y: begin
            div_start = 1'b1;
            div_num   = ua_y_ff;
         end
         OP_DIV_Y_WAIT: begin
            if (div_done) begin
               un_y_in = div_q;
            end
         end
         OP_UNIT_ZERO: begin
            un_x_in = '0;
            un_y_in = '0;
         end
         OP_FUT_MX: begin
            mul_a = {un_x_ff[31], un_x_ff};  mul_b = {2'b00, cfg.look};
            mul_en = 1'b1;
         end
         OP_FUT_AX: begin
            fx_in = sat_add(pos_x_ff, qfix(mp_ff));
            mul_a = {un_y_ff[31], un_y_ff};  mul_b = {2'b00, cfg.look};
            mul_en = 1'b1;
         end
         OP_FUT_AY: fy_in = sat_add(pos_y_ff, qfix(mp_ff));
         OP_FUT_D: begin
            dx_in   = sat_sub(fx_ff, cfg.begin_x);
            dy_in   = sat_sub(fy_ff, cfg.begin_y);
            ua_x_in = sat_sub(cfg.end_x, cfg.begin_x);
            ua_y_in = sat_sub(cfg.end_y, cfg.begin_y);
         end
         OP_DOT_M1: begin
            p_x_in = un_x_ff;
            p_y_in = un_y_ff;
            mul_a = {dx_ff[31], dx_ff};  mul_b = {un_x_ff[31], un_x_ff};
            mul_en = 1'b1;
         end
         OP_DOT_M2: begin
            acc_in = mp_ff;
            mul_a = {dy_ff[31], dy_ff};  mul_b = {p_y_ff[31], p_y_ff};
            mul_en = 1'b1;
         end
         OP_DOT_SUM: dot_in = qfix(acc_ff + mp_ff);
         OP_CL_MX: begin
            mul_a = {p_x_ff[31], p_x_ff};  mul_b = {dot_ff[31], dot_ff};
            mul_en = 1'b1;
         end
         OP_CL_MY: begin
            cx_in = sat_add(qfix(mp_ff), cfg.begin_x);
            mul_a = {p_y_ff[31], p_y_ff};  mul_b = {dot_ff[31], dot_ff};
            mul_en = 1'b1;
         end
         OP_AIM_X: begin
            cy_in    = sat_add(qfix(mp_ff), cfg.begin_y);
            aim_x_in = sat_add(cx_ff, times10(p_x_ff));
         end
         OP_AIM_Y: begin
            aim_y_in = sat_add(cy_ff, times10(p_y_ff));
            ua_x_in  = sat_sub(cx_ff, fx_ff);
            ua_y_in  = sat_sub(cy_ff, fy_ff);
         end
         OP_DIST: begin
            if (stat.len_over) begin
               steer_in = 1'b1;
               ua_x_in  = sat_sub(aim_x_ff, pos_x_ff);
               ua_y_in  = sat_sub(aim_y_ff, pos_y_ff);
            end
         end
         OP_SEEK_M1: begin
            mul_a = {un_x_ff[31], un_x_ff};  mul_b = {2'b00, cfg.speed};
            mul_en = 1'b1;
         end
         OP_SEEK_M2: begin
            ua_x_in = sat_sub(qfix(mp_ff), vel_x_ff);
            mul_a = {un_y_ff[31], un_y_ff};  mul_b = {2'b00, cfg.speed};
            mul_en = 1'b1;
         end
         OP_SEEK_M3: ua_y_in = sat_sub(qfix(mp_ff), vel_y_ff);
         OP_FRC_M1: begin
            mul_a = {un_x_ff[31], un_x_ff};  mul_b = {2'b00, cfg.force_mag};
            mul_en = 1'b1;
         end
         OP_FRC_M2: begin
            frc_x_in = qfix(mp_ff);
            mul_a = {un_y_ff[31], un_y_ff};  mul_b = {2'b00, cfg.force_mag};
            mul_en = 1'b1;
         end
         OP_FRC_M3: frc_y_in = qfix(mp_ff);
         default: ;
      endcase
      mp_in = mul_en ? (mul_a * mul_b) : mp_ff;
   end

   always_comb begin
      o_pos_x_in = o_pos_x_ff;  o_pos_y_in = o_pos_y_ff;
      o_vel_x_in = o_vel_x_ff;  o_vel_y_in = o_vel_y_ff;
      o_aim_x_in = o_aim_x_ff;  o_aim_y_in = o_aim_y_ff;
      o_steer_in = o_steer_ff;
      if (cmd.load_out) begin
         o_pos_x_in = pos_x_ff;  o_pos_y_in = pos_y_ff;
         o_vel_x_in = vel_x_ff;  o_vel_y_in = vel_y_ff;
         o_aim_x_in = aim_x_ff;  o_aim_y_in = aim_y_ff;
         o_steer_in = steer_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= VEL_RESET;
         vel_y_ff <= VEL_RESET;
         frc_x_ff <= '0;
         frc_y_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         frc_x_ff <= frc_x_in;
         frc_y_ff <= frc_y_in;
      end
      ua_x_ff  <= ua_x_in;   ua_y_ff  <= ua_y_in;
      un_x_ff  <= un_x_in;   un_y_ff  <= un_y_in;
      p_x_ff   <= p_x_in;    p_y_ff   <= p_y_in;
      fx_ff    <= fx_in;     fy_ff    <= fy_in;
      dx_ff    <= dx_in;     dy_ff    <= dy_in;
      dot_ff   <= dot_in;
      cx_ff    <= cx_in;     cy_ff    <= cy_in;
      aim_x_ff <= aim_x_in;  aim_y_ff <= aim_y_in;
      steer_ff <= steer_in;
      mp_ff    <= mp_in;
      acc_ff   <= acc_in;
      o_pos_x_ff <= o_pos_x_in;  o_pos_y_ff <= o_pos_y_in;
      o_vel_x_ff <= o_vel_x_in;  o_vel_y_ff <= o_vel_y_in;
      o_aim_x_ff <= o_aim_x_in;  o_aim_y_ff <= o_aim_y_in;
      o_steer_ff <= o_steer_in;
   end

   assign rsp_pos_x       = o_pos_x_ff;
   assign rsp_pos_y       = o_pos_y_ff;
   assign rsp_vel_x       = o_vel_x_ff;
   assign rsp_vel_y       = o_vel_y_ff;
   assign rsp_aim_x       = o_aim_x_ff;
   assign rsp_aim_y       = o_aim_y_ff;
   assign rsp_steering_on = o_steer_ff;

endmodule

`default_nettype wire

[src/pfs_ctrl.sv]
// Controller: sequences one tick or place request through the datapath.
// Depends on pfs_pkg for command and status types.
`default_nettype none

module pfs_ctrl import pfs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_mode,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_POS, S_SQX, S_SQY, S_SQRT, S_SQRT_WAIT,
      S_DIVX, S_DIVX_WAIT, S_DIVY, S_DIVY_WAIT, S_ZERO,
      S_FUT_MX, S_FUT_AX, S_FUT_AY, S_FUT_D,
      S_DOT_M1, S_DOT_M2, S_DOT_SUM, S_CL_MX, S_CL_MY, S_AIM_X, S_AIM_Y,
      S_DIST, S_SEEK_M1, S_SEEK_M2, S_SEEK_M3, S_FRC_M1, S_FRC_M2, S_FRC_M3,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      CALL_VEL, CALL_PATH, CALL_DIST, CALL_TGT, CALL_SEEK
   } call_type;

   state_type state_ff, state_in, ret_state;
   call_type  call_ff, call_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      case (call_ff)
         CALL_VEL:  ret_state = S_FUT_MX;
         CALL_PATH: ret_state = S_DOT_M1;
         CALL_TGT:  ret_state = S_SEEK_M1;
         CALL_SEEK: ret_state = S_FRC_M1;
         default:   ret_state = S_OUT;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      call_in      = call_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.load_out = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_TAKE;
               state_in = req_mode ? S_OUT : S_POS;
            end
         end
         S_POS: begin
            cmd.op   = OP_ADV_POS;
            call_in  = CALL_VEL;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.op   = OP_SQ_X;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = OP_SQ_Y;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op   = OP_SQRT;
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (stat.sqrt_done) begin
               if (call_ff == CALL_DIST) begin
                  state_in = S_DIST;
               end else if (stat.len_zero) begin
                  state_in = S_ZERO;
               end else begin
                  state_in = S_DIVX;
               end
            end
         end
         S_DIVX: begin
            cmd.op   = OP_DIV_X;
            state_in = S_DIVX_WAIT;
         end
         S_DIVX_WAIT: begin
            cmd.op = OP_DIV_X_WAIT;
            if (stat.div_done) begin
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            cmd.op   = OP_DIV_Y;
            state_in = S_DIVY_WAIT;
         end
         S_DIVY_WAIT: begin
            cmd.op = OP_DIV_Y_WAIT;
            if (stat.div_done) begin
               state_in = ret_state;
            end
         end
         S_ZERO: begin
            cmd.op   = OP_UNIT_ZERO;
            state_in = ret_state;
         end
         S_FUT_MX: begin
            cmd.op   = OP_FUT_MX;
            state_in = S_FUT_AX;
         end
         S_FUT_AX: begin
            cmd.op   = OP_FUT_AX;
            state_in = S_FUT_AY;
         end
         S_FUT_AY: begin
            cmd.op   = OP_FUT_AY;
            state_in = S_FUT_D;
         end
         S_FUT_D: begin
            cmd.op   = OP_FUT_D;
            call_in  = CALL_PATH;
            state_in = S_SQX;
         end
         S_DOT_M1: begin
            cmd.op   = OP_DOT_M1;
            state_in = S_DOT_M2;
         end
         S_DOT_M2: begin
            cmd.op   = OP_DOT_M2;
            state_in = S_DOT_SUM;
         end
         S_DOT_SUM: begin
            cmd.op   = OP_DOT_SUM;
            state_in = S_CL_MX;
         end
         S_CL_MX: begin
            cmd.op   = OP_CL_MX;
            state_in = S_CL_MY;
         end
         S_CL_MY: begin
            cmd.op   = OP_CL_MY;
            state_in = S_AIM_X;
         end
         S_AIM_X: begin
            cmd.op   = OP_AIM_X;
            state_in = S_AIM_Y;
         end
         S_AIM_Y: begin
            cmd.op   = OP_AIM_Y;
            call_in  = CALL_DIST;
            state_in = S_SQX;
         end
         S_DIST: begin
            cmd.op = OP_DIST;
            if (stat.len_over) begin
               call_in  = CALL_TGT;
               state_in = S_SQX;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SEEK_M1: begin
            cmd.op   = OP_SEEK_M1;
            state_in = S_SEEK_M2;
         end
         S_SEEK_M2: begin
            cmd.op   = OP_SEEK_M2;
            state_in = S_SEEK_M3;
         end
         S_SEEK_M3: begin
            cmd.op   = OP_SEEK_M3;
            call_in  = CALL_SEEK;
            state_in = S_SQX;
         end
         S_FRC_M1: begin
            cmd.op   = OP_FRC_M1;
            state_in = S_FRC_M2;
         end
         S_FRC_M2: begin
            cmd.op   = OP_FRC_M2;
            state_in = S_FRC_M3;
         end
         S_FRC_M3: begin
            cmd.op   = OP_FRC_M3;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         call_ff      <= CALL_VEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         call_ff      <= call_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/path_following_steering_core.sv]
// Path following steering core: one steering agent following a straight path.
// Depends on pfs_pkg, pfs_ifs, pfs_ctrl and pfs_datapath.
//
// Usage:
//   req channel (valid/ready): mode 0 advances one tick, mode 1 places the
//   agent at set_pos / set_vel. Every request yields exactly one response.
//   rsp channel (valid/ready): position and velocity after the request, the
//   aim point on the path and whether steering fired.
//   csr port: APB-style writes and reads of the path, radius, speed, force
//   and lookahead registers at byte address 4*index; pready is always high.
// Flow: a place request goes straight to the response. A tick runs two
//   normalizations and one length (four and one with steering) through a 32-step
//   square root and a 17-step divider; a zero-length vector skips the divider.
//   One request at a time; the next is taken once the response loads.
// Reset: agent at the origin with velocity 2.3 on both axes, no pending force,
//   registers at their defaults.
// Stall: a finished response is held in the output register; the next request
//   is taken meanwhile, and its response waits until the held one is taken.
`default_nettype none

module path_following_steering_core import pfs_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   pfs_req_if.sink                   req,
   pfs_rsp_if.source                 rsp,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   stat_type   stat;
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_PATH_BEGIN_X: cfg_in.begin_x   = csr_pwdata;
            REG_PATH_BEGIN_Y: cfg_in.begin_y   = csr_pwdata;
            REG_PATH_END_X:   cfg_in.end_x     = csr_pwdata;
            REG_PATH_END_Y:   cfg_in.end_y     = csr_pwdata;
            REG_PATH_RADIUS:  cfg_in.radius    = csr_pwdata[30:0];
            REG_MAX_SPEED:    cfg_in.speed     = csr_pwdata[30:0];
            REG_MAX_FORCE:    cfg_in.force_mag = csr_pwdata[30:0];
            REG_LOOKAHEAD:    cfg_in.look      = csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_PATH_BEGIN_X: csr_prdata = cfg_ff.begin_x;
         REG_PATH_BEGIN_Y: csr_prdata = cfg_ff.begin_y;
         REG_PATH_END_X:   csr_prdata = cfg_ff.end_x;
         REG_PATH_END_Y:   csr_prdata = cfg_ff.end_y;
         REG_PATH_RADIUS:  csr_prdata = {1'b0, cfg_ff.radius};
         REG_MAX_SPEED:    csr_prdata = {1'b0, cfg_ff.speed};
         REG_MAX_FORCE:    csr_prdata = {1'b0, cfg_ff.force_mag};
         REG_LOOKAHEAD:    csr_prdata = {1'b0, cfg_ff.look};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_x   <= '0;
         cfg_ff.begin_y   <= '0;
         cfg_ff.end_x     <= '0;
         cfg_ff.end_y     <= '0;
         cfg_ff.radius    <= '0;
         cfg_ff.speed     <= MAX_SPEED_RESET;
         cfg_ff.force_mag <= MAX_FORCE_RESET;
         cfg_ff.look      <= LOOKAHEAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg_ff),
      .req_mode        (req.mode),
      .req_set_pos_x   (req.set_pos_x),
      .req_set_pos_y   (req.set_pos_y),
      .req_set_vel_x   (req.set_vel_x),
      .req_set_vel_y   (req.set_vel_y),
      .stat            (stat),
      .rsp_pos_x       (rsp.pos_x),
      .rsp_pos_y       (rsp.pos_y),
      .rsp_vel_x       (rsp.vel_x),
      .rsp_vel_y       (rsp.vel_y),
      .rsp_aim_x       (rsp.aim_x),
      .rsp_aim_y       (rsp.aim_y),
      .rsp_steering_on (rsp.steering_on)
   );

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stat.sqrt_busy && stat.div_busy))
      else $error("square root and divider busy together");

   a_take_units_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_TAKE) |-> (!stat.sqrt_busy && !stat.div_busy))
      else $error("request taken while an arithmetic unit is busy");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp.valid || rsp.ready))
      else $error("response overwritten before it was taken");

endmodule

`default_nettype wire
